// ===== hw/rtl/vector_elementwise_alu_top_defines.svh =====
// Assertion macros shared by the vector ALU modules.
`ifndef VECTOR_ELEMENTWISE_ALU_TOP_DEFINES_SVH
`define VECTOR_ELEMENTWISE_ALU_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VEA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vea same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define VEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vea next-cycle check failed");

`endif

// ===== hw/rtl/vea_pkg.sv =====
package vea_pkg;

   // Widths fixed by the item fields and the register file
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH    = 32;
   localparam int MODE_WIDTH     = 4;
   localparam int CSR_IDX_WIDTH  = 1;

   // Register indexes of the write port
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MODE  = 1'b0,
      CSR_ALPHA = 1'b1
   } csr_idx_type;

   // Operation codes held in the mode register
   typedef enum logic [MODE_WIDTH-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_SCALE = 4'd4,
      OP_ADDA  = 4'd5,
      OP_AXPY  = 4'd6,
      OP_SUM   = 4'd7,
      OP_DOT   = 4'd8
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted item
      logic step;    // advance the shift-add / shift-subtract unit one bit
      logic finish;  // form the result and write the output register
   } vea_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic iter_op;   // the captured item needs the bit-serial unit
      logic cnt_last;  // this step is the final bit
      logic out_free;  // output register can take a result this cycle
   } vea_status_type;

endpackage

// ===== hw/rtl/vea_ctrl.sv =====
`include "vector_elementwise_alu_top_defines.svh"

module vea_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  vea_pkg::vea_status_type status,
   output vea_pkg::vea_cmd_type    cmd
);
   import vea_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!status.iter_op || status.cnt_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = status.iter_op;
         end
         ST_DONE: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `VEA_ASSERT_NEXT(a_load_to_run, clock, reset, cmd.load, state_ff == ST_RUN)
   `VEA_ASSERT_NEXT(a_short_op_done, clock, reset,
                    (state_ff == ST_RUN) && !status.iter_op, state_ff == ST_DONE)
   `VEA_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish,
                    status.out_free && !req_ready)

endmodule

// ===== hw/rtl/vea_dp.sv =====
`include "vector_elementwise_alu_top_defines.svh"

module vea_dp #(
   parameter int DATA_WIDTH = vea_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [vea_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [vea_pkg::FIELD_WIDTH-1:0]        csr_wr_data,
   input  logic signed [vea_pkg::FIELD_WIDTH-1:0] req_x_elem,
   input  logic signed [vea_pkg::FIELD_WIDTH-1:0] req_y_elem,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [vea_pkg::FIELD_WIDTH-1:0] rsp_result,
   output logic                                   rsp_result_last,
   output logic                                   rsp_div_zero,
   input  vea_pkg::vea_cmd_type                   cmd,
   output vea_pkg::vea_status_type                status
);
   import vea_pkg::*;

   localparam int CntWidth = $clog2(DATA_WIDTH);

   // Configuration registers
   logic [MODE_WIDTH-1:0]         mode_ff;
   logic signed [FIELD_WIDTH-1:0] alpha_ff;

   // Captured item
   op_type                       op_ff;
   logic signed [DATA_WIDTH-1:0] x_ff;
   logic signed [DATA_WIDTH-1:0] y_ff;
   logic                         last_ff;
   logic                         neg_ff;
   logic                         dz_ff;

   // Bit-serial unit: multiplicand or divisor, multiplier or dividend/quotient,
   // product or remainder
   logic [DATA_WIDTH-1:0] mcand_ff, mcand_in;
   logic [DATA_WIDTH-1:0] mplier_ff, mplier_in;
   logic [DATA_WIDTH-1:0] prod_ff, prod_in;
   logic [CntWidth-1:0]   cnt_ff;

   // Running total and output register
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  res_last_ff;
   logic                  res_dz_ff;

   // Operands read at the internal width
   logic signed [DATA_WIDTH-1:0] x_in, y_in, alpha_dw;
   logic [DATA_WIDTH-1:0]        x_mag, y_mag;
   op_type                       op_in;
   logic                         dz_in;
   logic [DATA_WIDTH:0]          shifted, diff;
   logic [DATA_WIDTH-1:0]        quot;

   // Take the low DATA_WIDTH bits of each field; a wider datapath fills with zeros
   assign x_in     = DATA_WIDTH'($unsigned(req_x_elem));
   assign y_in     = DATA_WIDTH'($unsigned(req_y_elem));
   assign alpha_dw = DATA_WIDTH'($unsigned(alpha_ff));
   assign op_in    = op_type'(mode_ff);
   assign x_mag    = x_in[DATA_WIDTH-1] ? DATA_WIDTH'(-x_in) : DATA_WIDTH'(x_in);
   assign y_mag    = y_in[DATA_WIDTH-1] ? DATA_WIDTH'(-y_in) : DATA_WIDTH'(y_in);
   assign dz_in    = (op_in == OP_DIV) && (y_in == '0);

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         alpha_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_MODE:  mode_ff  <= csr_wr_data[MODE_WIDTH-1:0];
            CSR_ALPHA: alpha_ff <= csr_wr_data;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         last_ff <= req_last;
         neg_ff  <= x_in[DATA_WIDTH-1] ^ y_in[DATA_WIDTH-1];
         dz_ff   <= dz_in;
      end
   end

   // One restoring-divide step on the remainder and dividend
   assign shifted = {prod_ff, mplier_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, mcand_ff};

   // Load operands or advance the bit-serial unit
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (cmd.load) begin
         prod_in = '0;
         case (op_in)
            OP_SCALE, OP_AXPY: begin
               mcand_in  = DATA_WIDTH'(alpha_dw);
               mplier_in = DATA_WIDTH'(x_in);
            end
            OP_DIV: begin
               mcand_in  = y_mag;
               mplier_in = x_mag;
            end
            default: begin
               mcand_in  = DATA_WIDTH'(x_in);
               mplier_in = DATA_WIDTH'(y_in);
            end
         endcase
      end else if (cmd.step) begin
         if (op_ff == OP_DIV) begin
            // keep the remainder when the trial subtract borrows
            prod_in   = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
            mplier_in = {mplier_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
         end else begin
            // shift-add multiply, low bits only since results wrap
            prod_in   = prod_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in  = {mcand_ff[DATA_WIDTH-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[DATA_WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   // Count the bits of the serial unit
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + CntWidth'(1);
      end
   end

   // Form the result of the captured item
   assign quot = neg_ff ? DATA_WIDTH'(-mplier_ff) : mplier_ff;

   always_comb begin
      case (op_ff)
         OP_ADD:   res_in = DATA_WIDTH'(x_ff + y_ff);
         OP_SUB:   res_in = DATA_WIDTH'(x_ff - y_ff);
         OP_MUL:   res_in = prod_ff;
         OP_DIV:   res_in = dz_ff ? '0 : quot;
         OP_SCALE: res_in = prod_ff;
         OP_ADDA:  res_in = DATA_WIDTH'(x_ff + alpha_dw);
         OP_AXPY:  res_in = prod_ff + DATA_WIDTH'(y_ff);
         OP_SUM:   res_in = acc_ff + DATA_WIDTH'(x_ff);
         OP_DOT:   res_in = acc_ff + prod_ff;
         default:  res_in = '0;
      endcase
   end

   // Update the running total, drop it at the end of a vector
   always_comb begin
      acc_in = acc_ff;
      if (cmd.finish) begin
         if (op_ff inside {OP_SUM, OP_DOT}) begin
            acc_in = res_in;
         end
         if (last_ff) begin
            acc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Output register: fill on finish, drain on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_ff      <= res_in;
         res_last_ff <= last_ff;
         res_dz_ff   <= dz_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = FIELD_WIDTH'(res_ff);
   assign rsp_result_last = res_last_ff;
   assign rsp_div_zero    = res_dz_ff;

   // Status toward the controller
   always_comb begin
      status.iter_op  = (op_ff inside {OP_MUL, OP_DIV, OP_SCALE, OP_AXPY, OP_DOT}) && !dz_ff;
      status.cnt_last = cnt_ff == CntWidth'(DATA_WIDTH - 1);
      status.out_free = !out_valid_ff || rsp_ready;
   end

   `VEA_ASSERT_NEXT(a_load_clears_cnt, clock, reset, cmd.load, cnt_ff == '0)
   `VEA_ASSERT_NEXT(a_last_clears_acc, clock, reset, cmd.finish && last_ff, acc_ff == '0)
   `VEA_ASSERT_NEXT(a_div_zero_result, clock, reset, cmd.finish && dz_ff,
                    rsp_valid && rsp_div_zero && (rsp_result == '0))

endmodule

// ===== hw/rtl/vector_elementwise_alu_top.sv =====
// Element-wise integer vector ALU. Each item carries one x/y element pair and
// a last mark and gives exactly one result: add, subtract, multiply, truncating
// divide, alpha*x, x+alpha, alpha*x+y, or the running sum of x or of x*y, as the
// mode register selects. Arithmetic wraps at DATA_WIDTH bits; the running total
// clears after every item marked last. Multiply, divide, scale, axpy and dot
// run on one shared radix-2 shift-add / shift-subtract unit, one bit per cycle,
// and no new item is accepted until the current one has formed its result;
// all other modes, and divide by zero, skip that unit. The result sits in an
// output register, so the next item is accepted while it waits to be taken.
// Write the mode and alpha registers only while idle.
module vector_elementwise_alu_top #(
   parameter int DATA_WIDTH = vea_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [vea_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [vea_pkg::FIELD_WIDTH-1:0]        csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [vea_pkg::FIELD_WIDTH-1:0] req_x_elem,
   input  logic signed [vea_pkg::FIELD_WIDTH-1:0] req_y_elem,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [vea_pkg::FIELD_WIDTH-1:0] rsp_result,
   output logic                                   rsp_result_last,
   output logic                                   rsp_div_zero
);
   import vea_pkg::*;

   vea_cmd_type    cmd;
   vea_status_type status;

   vea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vea_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_x_elem      (req_x_elem),
      .req_y_elem      (req_y_elem),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result      (rsp_result),
      .rsp_result_last (rsp_result_last),
      .rsp_div_zero    (rsp_div_zero),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
